>>> rtl/rbpa_pkg.sv
// Shared types and constants of the reference-counted block pool allocator.
package rbpa_pkg;

  localparam int POOL_BLOCKS_DEF = 64;
  localparam int MASK_WORDS_DEF  = 2;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int          WORD_BITS       = 32;
  localparam int          WORD_SHIFT      = 5;
  localparam logic [6:0]  USE_MAX         = 7'd127;
  localparam logic [6:0]  POOL_SIZE_RESET = 7'd64;
  localparam int          CFG_ADDR_BITS   = 3;
  localparam logic [2:0]  ADDR_POOL_SIZE  = 3'd0;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RETAIN  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOD
  } state_t;

  typedef struct packed {
    op_t        operation;
    logic [5:0] block_index;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] granted_index;
    logic [7:0] reference_count;
    logic [6:0] blocks_in_use;
    logic [6:0] blocks_in_use_peak;
  } out_item_t;

endpackage

>>> rtl/rbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/rbpa_core.sv
// Allocator sequencer: bitmap scan, reference count update and result register.
module rbpa_core #(
  parameter int POOL_BLOCKS = rbpa_pkg::POOL_BLOCKS_DEF,
  parameter int MASK_WORDS  = rbpa_pkg::MASK_WORDS_DEF,
  parameter int COUNT_BITS  = rbpa_pkg::COUNT_BITS_DEF,
  localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1,
  localparam int CW = $clog2(POOL_BLOCKS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pool_wr,
  input  logic [6:0]           pool_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbpa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbpa_pkg::out_item_t  out_data,
  output logic                 bm_wr_en,
  output logic [AW-1:0]        bm_wr_addr,
  output logic [31:0]          bm_wr_data,
  output logic                 bm_rd_en,
  output logic [AW-1:0]        bm_rd_addr,
  input  logic [31:0]          bm_rd_data,
  output logic                 cnt_wr_en,
  output logic [CW-1:0]        cnt_wr_addr,
  output logic [COUNT_BITS-1:0] cnt_wr_data,
  output logic                 cnt_rd_en,
  output logic [CW-1:0]        cnt_rd_addr,
  input  logic [COUNT_BITS-1:0] cnt_rd_data
);

  localparam int HW       = $clog2(MASK_WORDS + 1);
  localparam int GW       = AW + rbpa_pkg::WORD_SHIFT;
  localparam int BXW      = (CW > 6) ? CW : 6;
  localparam int CXW      = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam int CAPACITY = (POOL_BLOCKS < MASK_WORDS * rbpa_pkg::WORD_BITS) ?
                            POOL_BLOCKS : MASK_WORDS * rbpa_pkg::WORD_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  rbpa_pkg::state_t    state_r, state_nxt;
  rbpa_pkg::op_t       op_r, op_nxt;
  logic [5:0]          blk_r, blk_nxt;
  logic [HW-1:0]       w_r, w_nxt;
  logic [HW-1:0]       hint_r, hint_nxt;
  logic [6:0]          in_use_r, in_use_nxt;
  logic [6:0]          peak_r, peak_nxt;
  logic [MASK_WORDS-1:0] wvalid_r, wvalid_nxt;
  logic [CW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  rbpa_pkg::out_item_t out_r, out_nxt;

  logic [6:0]          pool_eff;
  logic                slot_free;
  logic                accept;
  logic                scan_end;
  logic                scan_hit;
  logic                clr_last;
  logic [AW-1:0]       scan_w;
  logic [31:0]         scan_word;
  logic [4:0]          top_bit;
  logic [31:0]         scan_left;
  logic [GW-1:0]       got;
  logic [6:0]          use_inc;
  logic [6:0]          use_dec;
  logic [GW-1:0]       blk_g;
  logic [BXW-1:0]      blk_x;
  logic [AW-1:0]       blk_w;
  logic [31:0]         blk_word;
  logic                blk_oor;
  logic                blk_alloc;
  logic [GW-1:0]       in_g;
  logic [BXW-1:0]      in_x;
  logic                in_oor;

  function automatic logic [31:0] fill_word(input logic [AW-1:0] w, input logic [6:0] n);
    logic [10:0] base;
    logic [10:0] nn;
    logic [4:0]  rem;
    base = 11'({w, 5'd0});
    nn   = 11'(n);
    rem  = 5'(nn - base);
    if (nn >= base + 11'd32) begin
      fill_word = '1;
    end else if (nn <= base) begin
      fill_word = '0;
    end else begin
      fill_word = (32'h1 << rem) - 32'h1;
    end
  endfunction

  function automatic logic [7:0] low8(input logic [COUNT_BITS-1:0] c);
    logic [CXW-1:0] x;
    x = CXW'(c);
    low8 = x[7:0];
  endfunction

  always_comb begin
    if (11'(pool_size) > 11'(CAPACITY)) begin
      pool_eff = 7'(CAPACITY);
    end else begin
      pool_eff = pool_size;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && (state_r == rbpa_pkg::S_IDLE);
  assign in_ready  = (state_r == rbpa_pkg::S_IDLE);
  assign clr_last  = (clr_r == CW'(POOL_BLOCKS - 1));

  assign in_g   = GW'(in_data.block_index);
  assign in_x   = BXW'(in_data.block_index);
  assign in_oor = (32'(in_data.block_index) >= 32'(CAPACITY));

  // allocate scan
  assign scan_w    = w_r[AW-1:0];
  assign scan_end  = (32'(w_r) >= 32'(MASK_WORDS));
  assign scan_word = wvalid_r[scan_w] ? bm_rd_data : fill_word(scan_w, pool_eff);
  assign scan_hit  = !scan_end && (scan_word != 32'h0);

  always_comb begin
    top_bit = 5'd0;
    for (int i = 0; i < rbpa_pkg::WORD_BITS; i++) begin
      if (scan_word[i]) begin
        top_bit = 5'(i);
      end
    end
  end

  assign scan_left = scan_word & ~(32'h1 << top_bit);
  assign got       = {scan_w, top_bit};
  assign use_inc   = (in_use_r < rbpa_pkg::USE_MAX) ? in_use_r + 7'd1 : in_use_r;
  assign use_dec   = (in_use_r > 7'd0) ? in_use_r - 7'd1 : in_use_r;

  // release / retain
  assign blk_g     = GW'(blk_r);
  assign blk_x     = BXW'(blk_r);
  assign blk_w     = blk_g[GW-1:rbpa_pkg::WORD_SHIFT];
  assign blk_oor   = (32'(blk_r) >= 32'(CAPACITY));
  assign blk_word  = wvalid_r[blk_w] ? bm_rd_data : fill_word(blk_w, pool_eff);
  assign blk_alloc = !blk_word[blk_r[4:0]] && (cnt_rd_data != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbpa_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = rbpa_pkg::S_IDLE;
        end
      end
      rbpa_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == rbpa_pkg::OP_ALLOC) ?
                      rbpa_pkg::S_SCAN : rbpa_pkg::S_MOD;
        end
      end
      rbpa_pkg::S_SCAN: begin
        if ((scan_end || scan_hit) && slot_free) begin
          state_nxt = rbpa_pkg::S_IDLE;
        end
      end
      rbpa_pkg::S_MOD: begin
        if (slot_free) begin
          state_nxt = rbpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = rbpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    blk_nxt       = blk_r;
    w_nxt         = w_r;
    hint_nxt      = hint_r;
    in_use_nxt    = in_use_r;
    peak_nxt      = peak_r;
    wvalid_nxt    = wvalid_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    bm_wr_en      = 1'b0;
    bm_wr_addr    = scan_w;
    bm_wr_data    = scan_left;
    bm_rd_en      = 1'b0;
    bm_rd_addr    = hint_r[AW-1:0];
    cnt_wr_en     = 1'b0;
    cnt_wr_addr   = clr_r;
    cnt_wr_data   = '0;
    cnt_rd_en     = 1'b0;
    cnt_rd_addr   = in_x[CW-1:0];

    unique case (state_r)
      rbpa_pkg::S_CLEAR: begin
        cnt_wr_en = 1'b1;
        clr_nxt   = clr_r + CW'(1);
      end
      rbpa_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt  = in_data.operation;
          blk_nxt = in_data.block_index;
          w_nxt   = hint_r;
          if (in_data.operation == rbpa_pkg::OP_ALLOC) begin
            bm_rd_addr = hint_r[AW-1:0];
            bm_rd_en   = (32'(hint_r) < 32'(MASK_WORDS));
          end else begin
            bm_rd_addr = in_g[GW-1:rbpa_pkg::WORD_SHIFT];
            bm_rd_en   = !in_oor;
            cnt_rd_en  = !in_oor;
          end
        end
      end
      rbpa_pkg::S_SCAN: begin
        if (scan_end) begin
          if (slot_free) begin
            out_valid_nxt                = 1'b1;
            out_nxt.status               = rbpa_pkg::ST_EMPTY;
            out_nxt.granted_index        = 6'd0;
            out_nxt.reference_count      = 8'd0;
            out_nxt.blocks_in_use        = in_use_r;
            out_nxt.blocks_in_use_peak   = peak_r;
          end
        end else if (scan_hit) begin
          if (slot_free) begin
            bm_wr_en           = 1'b1;
            bm_wr_addr         = scan_w;
            bm_wr_data         = scan_left;
            wvalid_nxt[scan_w] = 1'b1;
            hint_nxt           = (scan_left != 32'h0) ? w_r : w_r + HW'(1);
            cnt_wr_en          = (32'(got) < 32'(POOL_BLOCKS));
            cnt_wr_addr        = CW'(got);
            cnt_wr_data        = COUNT_BITS'(1);
            in_use_nxt         = use_inc;
            peak_nxt           = (use_inc > peak_r) ? use_inc : peak_r;
            out_valid_nxt                = 1'b1;
            out_nxt.status               = rbpa_pkg::ST_OK;
            out_nxt.granted_index        = got[5:0];
            out_nxt.reference_count      = 8'd1;
            out_nxt.blocks_in_use        = use_inc;
            out_nxt.blocks_in_use_peak   = (use_inc > peak_r) ? use_inc : peak_r;
          end
        end else begin
          // advance to the next word
          w_nxt      = w_r + HW'(1);
          bm_rd_addr = AW'(w_r + HW'(1));
          bm_rd_en   = (32'(w_r) + 32'd1 < 32'(MASK_WORDS));
        end
      end
      rbpa_pkg::S_MOD: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_nxt.status             = rbpa_pkg::ST_OK;
          out_nxt.granted_index      = blk_r;
          out_nxt.reference_count    = blk_oor ? 8'd0 : low8(cnt_rd_data);
          out_nxt.blocks_in_use      = in_use_r;
          out_nxt.blocks_in_use_peak = peak_r;
          cnt_wr_addr                = blk_x[CW-1:0];
          bm_wr_addr                 = blk_w;
          bm_wr_data                 = blk_word | (32'h1 << blk_r[4:0]);
          if (blk_oor) begin
            if (op_r != rbpa_pkg::OP_NOP) begin
              out_nxt.status = rbpa_pkg::ST_BAD;
            end
          end else if (op_r == rbpa_pkg::OP_NOP) begin
            out_nxt.status = rbpa_pkg::ST_OK;
          end else if (!blk_alloc) begin
            out_nxt.status = rbpa_pkg::ST_BAD;
          end else if (op_r == rbpa_pkg::OP_RELEASE) begin
            cnt_wr_en = 1'b1;
            if (cnt_rd_data > COUNT_BITS'(1)) begin
              cnt_wr_data             = cnt_rd_data - COUNT_BITS'(1);
              out_nxt.reference_count = low8(cnt_rd_data - COUNT_BITS'(1));
            end else begin
              cnt_wr_data             = '0;
              out_nxt.reference_count = 8'd0;
              bm_wr_en                = 1'b1;
              wvalid_nxt[blk_w]       = 1'b1;
              if (HW'(blk_w) < hint_r) begin
                hint_nxt = HW'(blk_w);
              end
              in_use_nxt                 = use_dec;
              out_nxt.blocks_in_use      = use_dec;
            end
          end else begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = (cnt_rd_data == COUNT_MAX) ? cnt_rd_data :
                          cnt_rd_data + COUNT_BITS'(1);
            out_nxt.reference_count = low8((cnt_rd_data == COUNT_MAX) ? cnt_rd_data :
                                           cnt_rd_data + COUNT_BITS'(1));
          end
        end
      end
      default: begin
      end
    endcase

    if (pool_wr) begin
      wvalid_nxt = '0;
      hint_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbpa_pkg::S_CLEAR;
      hint_r      <= '0;
      in_use_r    <= '0;
      peak_r      <= '0;
      wvalid_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      in_use_r    <= in_use_nxt;
      peak_r      <= peak_nxt;
      wvalid_r    <= wvalid_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    blk_r <= blk_nxt;
    w_r   <= w_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/refcounted_block_pool_allocator.sv
// Top level of the reference-counted block pool allocator with its register port.
//
// Hands out blocks from a pool of POOL_BLOCKS, tracked by a free bitmap of MASK_WORDS
// 32-bit words and a COUNT_BITS reference count per block, both held in RAMs with a
// registered read. One item is worked on at a time. Release, retain and the unused
// code issue the bitmap and count reads when the item is accepted; the modify and
// write-back follow in S_MOD once the output register is free. Allocate reads the
// bitmap word at the first-free-word hint and steps on past every empty word; a scan
// that runs off the last word reports an empty pool. The result sits in an output
// register, so the next item is accepted while it waits. After reset a clearing pass
// zeroes the reference counts of all POOL_BLOCKS blocks; no item is accepted until it
// ends, while register writes are taken throughout. Writing pool_size resets the
// bitmap and hint at once; counts, usage and peak stay.
module refcounted_block_pool_allocator #(
  parameter int POOL_BLOCKS = rbpa_pkg::POOL_BLOCKS_DEF,
  parameter int MASK_WORDS  = rbpa_pkg::MASK_WORDS_DEF,
  parameter int COUNT_BITS  = rbpa_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [rbpa_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rbpa_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rbpa_pkg::out_item_t                  out_data
);

  localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int CW = $clog2(POOL_BLOCKS);

  logic [6:0]            pool_size_r, pool_size_nxt;
  logic                  pool_wr;

  logic                  bm_wr_en;
  logic [AW-1:0]         bm_wr_addr;
  logic [31:0]           bm_wr_data;
  logic                  bm_rd_en;
  logic [AW-1:0]         bm_rd_addr;
  logic [31:0]           bm_rd_data;
  logic                  cnt_wr_en;
  logic [CW-1:0]         cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;
  logic                  cnt_rd_en;
  logic [CW-1:0]         cnt_rd_addr;
  logic [COUNT_BITS-1:0] cnt_rd_data;

  assign cfg_pready    = 1'b1;
  assign pool_wr       = cfg_psel && cfg_penable && cfg_pwrite &&
                         (cfg_paddr == rbpa_pkg::ADDR_POOL_SIZE);
  assign pool_size_nxt = pool_wr ? cfg_pwdata[6:0] : pool_size_r;
  assign cfg_prdata    = (cfg_paddr == rbpa_pkg::ADDR_POOL_SIZE) ?
                         32'(pool_size_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= rbpa_pkg::POOL_SIZE_RESET;
    end else begin
      pool_size_r <= pool_size_nxt;
    end
  end

  rbpa_ram #(
    .WIDTH (32),
    .DEPTH (MASK_WORDS)
  ) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  rbpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (POOL_BLOCKS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  rbpa_core #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .MASK_WORDS  (MASK_WORDS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .pool_wr     (pool_wr),
    .pool_size   (pool_size_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .bm_wr_en    (bm_wr_en),
    .bm_wr_addr  (bm_wr_addr),
    .bm_wr_data  (bm_wr_data),
    .bm_rd_en    (bm_rd_en),
    .bm_rd_addr  (bm_rd_addr),
    .bm_rd_data  (bm_rd_data),
    .cnt_wr_en   (cnt_wr_en),
    .cnt_wr_addr (cnt_wr_addr),
    .cnt_wr_data (cnt_wr_data),
    .cnt_rd_en   (cnt_rd_en),
    .cnt_rd_addr (cnt_rd_addr),
    .cnt_rd_data (cnt_rd_data)
  );

endmodule
